>>> rtl/smm_pkg.sv
package smm_pkg;

   // Largest matrix dimension the stores are built for.
   localparam int SMM_MAX_SIZE = 8;

   // Field widths of the stream and configuration ports.
   localparam int FUNC_W  = 2;
   localparam int IDX_W   = 3;
   localparam int VAL_W   = 32;
   localparam int SIZE_W  = 4;
   localparam int TDATA_W = 40;

   localparam logic [SIZE_W-1:0] SIZE_RESET = 4'd8;

   // Operation codes carried in tuser.
   localparam logic [FUNC_W-1:0] FUNC_WRITE_FIRST  = 2'd0;
   localparam logic [FUNC_W-1:0] FUNC_WRITE_SECOND = 2'd1;
   localparam logic [FUNC_W-1:0] FUNC_COMPUTE      = 2'd2;

   // Position of one read beat inside the dot product of one element.
   typedef struct packed {
      logic first;
      logic last;
   } smm_tag_type;

endpackage

>>> rtl/smm_ram.sv
module smm_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             we,
   input  logic [AW-1:0]    waddr,
   input  logic [WIDTH-1:0] wdata,
   input  logic [AW-1:0]    raddr,
   output logic [WIDTH-1:0] rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   // One write port and one registered read port.
   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule

>>> rtl/smm_mac.sv
module smm_mac (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      rd_valid,
   input  smm_pkg::smm_tag_type      rd_tag,
   input  logic [smm_pkg::VAL_W-1:0] a,
   input  logic [smm_pkg::VAL_W-1:0] b,
   output logic                      res_valid,
   output logic [smm_pkg::VAL_W-1:0] res
);
   import smm_pkg::*;

   logic              prod_valid_ff;
   smm_tag_type       prod_tag_ff;
   logic [VAL_W-1:0]  prod_ff;
   logic [VAL_W-1:0]  acc_ff;
   logic [VAL_W-1:0]  acc_in;
   logic [2*VAL_W-1:0] full_prod;

   // Multiply stage; only the low word matters for a wrapping sum.
   assign full_prod = a * b;

   always_ff @(posedge clock) begin
      if (reset) begin
         prod_valid_ff <= 1'b0;
      end else begin
         prod_valid_ff <= rd_valid;
      end
      prod_tag_ff <= rd_tag;
      prod_ff     <= full_prod[VAL_W-1:0];
   end

   // Accumulate stage; the first term of an element restarts the sum.
   always_comb begin
      acc_in = (prod_tag_ff.first ? '0 : acc_ff) + prod_ff;
   end

   always_ff @(posedge clock) begin
      if (prod_valid_ff) begin
         acc_ff <= acc_in;
      end
   end

   assign res_valid = prod_valid_ff && prod_tag_ff.last;
   assign res       = acc_in;

endmodule

>>> rtl/square_integer_matrix_multiply_core.sv
// Write beats produce no response.
// A compute beat emits n*n elements, n being the configured size clamped to the range
// one to MAX_SIZE; each element takes n reads of both matrix memories through their single
// read ports feeding one shared multiply-accumulate unit, plus pipeline drain.
// Reset is synchronous; it sets the size to eight and leaves matrix contents undefined.
module square_integer_matrix_multiply_core #(
   parameter int MAX_SIZE = smm_pkg::SMM_MAX_SIZE
) (
   input  logic                        clock,
   input  logic                        reset,
   // Request stream.
   input  logic                        req_tvalid,
   output logic                        req_tready,
   input  logic [smm_pkg::TDATA_W-1:0] req_tdata,  // row[2:0], col[5:3], value[37:6]
   input  logic [smm_pkg::FUNC_W-1:0]  req_tuser,  // func[1:0]
   // Response stream.
   output logic                        rsp_tvalid,
   input  logic                        rsp_tready,
   output logic [smm_pkg::TDATA_W-1:0] rsp_tdata,  // out_row[2:0], out_col[5:3], product[37:6]
   output logic                        rsp_tlast,
   // Size register.
   input  logic                        csr_we,
   input  logic [smm_pkg::SIZE_W-1:0]  csr_wdata
);
   import smm_pkg::*;

   localparam int DEPTH = MAX_SIZE * MAX_SIZE;
   localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

   typedef enum logic [3:0] {
      ST_IDLE  = 4'b0001,
      ST_WAIT  = 4'b0010,
      ST_ISSUE = 4'b0100,
      ST_DRAIN = 4'b1000
   } state_type;

   state_type         state_ff, state_in;
   logic [SIZE_W-1:0] size_ff;
   logic [IDX_W-1:0]  n_m1;
   logic [IDX_W-1:0]  r_ff, r_in, c_ff, c_in, k_ff, k_in;
   logic              iss_valid_ff, iss_valid_in;
   smm_tag_type       iss_tag_ff, iss_tag_in;
   logic              rsp_valid_ff;
   logic [TDATA_W-1:0] rsp_data_ff;
   logic              rsp_last_ff;

   logic [IDX_W-1:0]  req_row, req_col;
   logic [VAL_W-1:0]  req_value;
   logic              req_beat, in_range;
   logic              we_first, we_second;
   logic [AW-1:0]     waddr, raddr_first, raddr_second;
   logic [VAL_W-1:0]  rd_first, rd_second;
   logic              res_valid;
   logic [VAL_W-1:0]  res;
   logic              last_elem;

   assign req_row   = req_tdata[2:0];
   assign req_col   = req_tdata[5:3];
   assign req_value = req_tdata[37:6];

   // Size register and its clamped value, kept as size minus one.
   always_ff @(posedge clock) begin
      if (reset) begin
         size_ff <= SIZE_RESET;
      end else if (csr_we) begin
         size_ff <= csr_wdata;
      end
   end

   always_comb begin
      if (size_ff == '0) begin
         n_m1 = '0;
      end else if (32'(size_ff) > MAX_SIZE) begin
         n_m1 = IDX_W'(MAX_SIZE - 1);
      end else begin
         n_m1 = IDX_W'(size_ff - 1'b1);
      end
   end

   // Element writes go straight to the stores while idle.
   assign req_tready = (state_ff == ST_IDLE);
   assign req_beat   = req_tvalid && req_tready;
   assign in_range   = (32'(req_row) < MAX_SIZE) && (32'(req_col) < MAX_SIZE);
   assign we_first   = req_beat && in_range && (req_tuser == FUNC_WRITE_FIRST);
   assign we_second  = req_beat && in_range && (req_tuser == FUNC_WRITE_SECOND);
   assign waddr      = AW'(32'(req_row) * MAX_SIZE + 32'(req_col));

   // Read addresses: first[r][k] and second[k][c].
   assign raddr_first  = AW'(32'(r_ff) * MAX_SIZE + 32'(k_ff));
   assign raddr_second = AW'(32'(k_ff) * MAX_SIZE + 32'(c_ff));

   smm_ram #(.WIDTH(VAL_W), .DEPTH(DEPTH)) u_first (
      .clock (clock),
      .we    (we_first),
      .waddr (waddr),
      .wdata (req_value),
      .raddr (raddr_first),
      .rdata (rd_first)
   );

   smm_ram #(.WIDTH(VAL_W), .DEPTH(DEPTH)) u_second (
      .clock (clock),
      .we    (we_second),
      .waddr (waddr),
      .wdata (req_value),
      .raddr (raddr_second),
      .rdata (rd_second)
   );

   smm_mac u_mac (
      .clock     (clock),
      .reset     (reset),
      .rd_valid  (iss_valid_ff),
      .rd_tag    (iss_tag_ff),
      .a         (rd_first),
      .b         (rd_second),
      .res_valid (res_valid),
      .res       (res)
   );

   assign last_elem = (r_ff == n_m1) && (c_ff == n_m1);

   // Sequencer: wait for a free response slot, issue n reads, drain the sum.
   always_comb begin
      state_in     = state_ff;
      r_in         = r_ff;
      c_in         = c_ff;
      k_in         = k_ff;
      iss_valid_in = 1'b0;
      iss_tag_in   = '{first: (k_ff == '0), last: (k_ff == n_m1)};
      unique case (state_ff)
         ST_IDLE: begin
            if (req_beat && req_tuser == FUNC_COMPUTE) begin
               r_in     = '0;
               c_in     = '0;
               k_in     = '0;
               state_in = ST_WAIT;
            end
         end
         ST_WAIT: begin
            if (!rsp_valid_ff || rsp_tready) begin
               state_in = ST_ISSUE;
            end
         end
         ST_ISSUE: begin
            iss_valid_in = 1'b1;
            if (k_ff == n_m1) begin
               k_in     = '0;
               state_in = ST_DRAIN;
            end else begin
               k_in = k_ff + 1'b1;
            end
         end
         ST_DRAIN: begin
            if (res_valid) begin
               if (c_ff == n_m1) begin
                  c_in = '0;
                  r_in = r_ff + 1'b1;
               end else begin
                  c_in = c_ff + 1'b1;
               end
               state_in = last_elem ? ST_IDLE : ST_WAIT;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         iss_valid_ff <= 1'b0;
         r_ff         <= '0;
         c_ff         <= '0;
         k_ff         <= '0;
      end else begin
         state_ff     <= state_in;
         iss_valid_ff <= iss_valid_in;
         r_ff         <= r_in;
         c_ff         <= c_in;
         k_ff         <= k_in;
      end
      iss_tag_ff <= iss_tag_in;
   end

   // Response register holds one finished element until its beat is taken.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (res_valid) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
      if (res_valid) begin
         rsp_data_ff <= {2'b00, res, c_ff, r_ff};
         rsp_last_ff <= last_elem;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tlast  = rsp_last_ff;

   // A finished sum only appears while draining and never lands on a full slot.
   a_res_in_drain: assert property (@(posedge clock) disable iff (reset)
      res_valid |-> (state_ff == ST_DRAIN))
      else $error("sum finished outside drain");

   a_res_slot_free: assert property (@(posedge clock) disable iff (reset)
      res_valid |-> !rsp_valid_ff)
      else $error("sum overwrote a pending response");

   a_issue_slot_free: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_ISSUE) |-> !rsp_valid_ff)
      else $error("reads issued while response slot full");

   a_read_follows_issue: assert property (@(posedge clock) disable iff (reset)
      iss_valid_ff |-> ($past(state_ff) == ST_ISSUE))
      else $error("read beat without issue");

endmodule

>>> tb/matrix_product_checker.sv
module matrix_product_checker
   import smm_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               req_tvalid,
   input  logic               req_tready,
   input  logic [TDATA_W-1:0] req_tdata,   // row[2:0], col[5:3], value[37:6]
   input  logic [FUNC_W-1:0]  req_tuser,   // func[1:0]
   input  logic               rsp_tvalid,
   input  logic               rsp_tready,
   input  logic [TDATA_W-1:0] rsp_tdata,   // out_row[2:0], out_col[5:3], product[37:6]
   input  logic               rsp_tlast,
   input  logic               csr_we,
   input  logic [SIZE_W-1:0]  csr_wdata,
   output int                 mismatch_count,
   output int                 outstanding
);

   localparam int STORE_DEPTH = SMM_MAX_SIZE * SMM_MAX_SIZE;

   typedef struct packed {
      logic [IDX_W-1:0] row;
      logic [IDX_W-1:0] col;
      logic [VAL_W-1:0] product;
      logic             last;
   } product_beat_type;

   // Shadow copies of both matrices and of the size register.
   logic [VAL_W-1:0]  first_store [STORE_DEPTH];
   logic [VAL_W-1:0]  second_store [STORE_DEPTH];
   logic [SIZE_W-1:0] size_reg;
   product_beat_type  expected_products [$];

   // All channels are sampled at the rising edge, where beats are accepted.
   always @(posedge clock) begin : monitor
      product_beat_type got;
      product_beat_type want;
      product_beat_type beat;
      logic [VAL_W-1:0] acc;
      logic [IDX_W-1:0] row;
      logic [IDX_W-1:0] col;
      int               dim;
      if (reset) begin
         expected_products.delete();
         size_reg = SIZE_RESET;
         mismatch_count = 0;
      end else begin
         // Result beats are checked first, so that a result arriving on the
         // same edge as a new compute beat cannot hide behind it.
         if (rsp_tvalid && rsp_tready) begin
            got.row = rsp_tdata[IDX_W-1:0];
            got.col = rsp_tdata[2*IDX_W-1:IDX_W];
            got.product = rsp_tdata[2*IDX_W+VAL_W-1:2*IDX_W];
            got.last = rsp_tlast;
            if (expected_products.size() == 0) begin
               $display("%0t: unexpected result beat row %0d col %0d product %0d last %0b",
                        $time, got.row, got.col, $signed(got.product), got.last);
               mismatch_count++;
            end else begin
               want = expected_products.pop_front();
               if (got !== want) begin
                  $display("%0t: result mismatch, expected row %0d col %0d product %0d last %0b",
                           $time, want.row, want.col, $signed(want.product), want.last);
                  $display("%0t:                  actual row %0d col %0d product %0d last %0b",
                           $time, got.row, got.col, $signed(got.product), got.last);
                  mismatch_count++;
               end
            end
         end

         // Request beats update the stores or queue a whole product.
         if (req_tvalid && req_tready) begin
            row = req_tdata[IDX_W-1:0];
            col = req_tdata[2*IDX_W-1:IDX_W];
            case (req_tuser)
               FUNC_WRITE_FIRST: begin
                  first_store[row * SMM_MAX_SIZE + col] = req_tdata[2*IDX_W+VAL_W-1:2*IDX_W];
               end
               FUNC_WRITE_SECOND: begin
                  second_store[row * SMM_MAX_SIZE + col] = req_tdata[2*IDX_W+VAL_W-1:2*IDX_W];
               end
               FUNC_COMPUTE: begin
                  // A size of zero acts as one; sizes above the store saturate.
                  if (size_reg == 0)
                     dim = 1;
                  else if (size_reg > SMM_MAX_SIZE)
                     dim = SMM_MAX_SIZE;
                  else
                     dim = int'(size_reg);
                  for (int r = 0; r < dim; r++) begin
                     for (int c = 0; c < dim; c++) begin
                        acc = '0;
                        for (int k = 0; k < dim; k++) begin
                           acc = acc + first_store[r * SMM_MAX_SIZE + k] *
                                       second_store[k * SMM_MAX_SIZE + c];
                        end
                        beat.row = IDX_W'(r);
                        beat.col = IDX_W'(c);
                        beat.product = acc;
                        beat.last = (r == dim - 1) && (c == dim - 1);
                        expected_products.push_back(beat);
                     end
                  end
               end
               default: begin
                  // The spare code is ignored by the block.
               end
            endcase
         end

         if (csr_we) begin
            size_reg = csr_wdata;
         end
      end
      outstanding = expected_products.size();
   end

endmodule

>>> tb/testbench.sv
module testbench;
   import smm_pkg::*;

   localparam logic [FUNC_W-1:0] FUNC_UNUSED = 2'd3;
   localparam int STORE_DEPTH = SMM_MAX_SIZE * SMM_MAX_SIZE;
   localparam int ITEM_TARGET = 310;
   localparam int IDLE_PERCENT = 22;
   localparam int SETTLE_CYCLES = 24;
   localparam int STALL_LIMIT = 4000;

   logic               clock = 1'b0;
   logic               reset;
   logic               req_tvalid;
   logic               req_tready;
   logic [TDATA_W-1:0] req_tdata;   // row[2:0], col[5:3], value[37:6]
   logic [FUNC_W-1:0]  req_tuser;   // func[1:0]
   logic               rsp_tvalid;
   logic               rsp_tready;
   logic [TDATA_W-1:0] rsp_tdata;   // out_row[2:0], out_col[5:3], product[37:6]
   logic               rsp_tlast;
   logic               csr_we;
   logic [SIZE_W-1:0]  csr_wdata;
   int                 mismatch_count;
   int                 outstanding;
   int                 items_sent = 0;
   int                 idle_cycles = 0;
   logic               steady;
   bit                 first_loaded [STORE_DEPTH];
   bit                 second_loaded [STORE_DEPTH];

   square_integer_matrix_multiply_core uut (.*);

   matrix_product_checker checker_inst (.*);

   always #1 clock = ~clock;

   // A window of items where neither side idles.
   assign steady = (items_sent >= 150) && (items_sent < 210);

   // Result side stalls at random, except in the steady window.
   always @(negedge clock) begin
      rsp_tready <= steady || ($urandom_range(0, 99) >= IDLE_PERCENT);
   end

   // Watchdog on cycles without any accepted beat.
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= STALL_LIMIT) begin
         $display("** square_integer_matrix_multiply_core: FAILED **");
         $finish;
      end
   end

   // Presents one request beat, with random gaps ahead of it, and returns at
   // the falling edge after it was accepted.
   task automatic send_beat(input logic [FUNC_W-1:0] func, input logic [IDX_W-1:0] row,
                            input logic [IDX_W-1:0] col, input logic [VAL_W-1:0] value);
      while (!steady && $urandom_range(0, 99) < IDLE_PERCENT) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser <= func;
      req_tdata <= TDATA_W'({value, col, row});
      do @(posedge clock); while (!req_tready);
      if (func != FUNC_UNUSED)
         items_sent++;
      @(negedge clock);
   endtask

   // Writes one matrix element and remembers that it holds a value now.
   task automatic load_element(input logic [FUNC_W-1:0] func, input logic [IDX_W-1:0] row,
                               input logic [IDX_W-1:0] col, input logic [VAL_W-1:0] value);
      send_beat(func, row, col, value);
      if (func == FUNC_WRITE_FIRST)
         first_loaded[row * SMM_MAX_SIZE + col] = 1'b1;
      else
         second_loaded[row * SMM_MAX_SIZE + col] = 1'b1;
   endtask

   // Holds the request side until every expected product is out and the
   // block has had time to finish any write still in flight.
   task automatic settle();
      req_tvalid <= 1'b0;
      while (outstanding != 0)
         @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic set_size(input logic [SIZE_W-1:0] code);
      settle();
      csr_we <= 1'b1;
      csr_wdata <= code;
      @(negedge clock);
      csr_we <= 1'b0;
   endtask

   // Element values lean toward the extremes so that sums wrap often.
   function automatic logic [VAL_W-1:0] pick_value();
      case ($urandom_range(0, 5))
         0: return 32'h8000_0000;
         1: return 32'h7FFF_FFFF;
         2: return VAL_W'($urandom_range(0, 31)) - 32'd16;
         default: return $urandom;
      endcase
   endfunction

   function automatic logic [FUNC_W-1:0] pick_matrix();
      return ($urandom_range(0, 1) != 0) ? FUNC_WRITE_SECOND : FUNC_WRITE_FIRST;
   endfunction

   initial begin
      logic [SIZE_W-1:0] size_code;
      int                dim;
      reset = 1'b1;
      req_tvalid = 1'b0;
      req_tdata = '0;
      req_tuser = '0;
      csr_we = 1'b0;
      csr_wdata = '0;
      repeat (4) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Single element: most negative times minus one wraps onto itself.
      set_size(4'd1);
      load_element(FUNC_WRITE_FIRST, 3'd0, 3'd0, 32'h8000_0000);
      load_element(FUNC_WRITE_SECOND, 3'd0, 3'd0, 32'hFFFF_FFFF);
      // Writes outside the active square but inside the store are kept.
      load_element(FUNC_WRITE_FIRST, 3'd7, 3'd7, 32'h7FFF_FFFF);
      load_element(FUNC_WRITE_SECOND, 3'd7, 3'd7, 32'h7FFF_FFFF);
      // The spare code must leave everything alone.
      send_beat(FUNC_UNUSED, 3'd7, 3'd7, 32'hFFFF_FFFF);
      send_beat(FUNC_COMPUTE, 3'd7, 3'd7, 32'hFFFF_FFFF);
      // A size of zero behaves as one.
      set_size(4'd0);
      send_beat(FUNC_COMPUTE, 3'd0, 3'd0, 32'h0000_0000);
      // Two by two with extreme values.
      set_size(4'd2);
      load_element(FUNC_WRITE_FIRST, 3'd0, 3'd1, 32'h7FFF_FFFF);
      load_element(FUNC_WRITE_FIRST, 3'd1, 3'd0, 32'h8000_0000);
      load_element(FUNC_WRITE_FIRST, 3'd1, 3'd1, 32'h0000_0001);
      load_element(FUNC_WRITE_SECOND, 3'd0, 3'd1, 32'h7FFF_FFFF);
      load_element(FUNC_WRITE_SECOND, 3'd1, 3'd0, 32'h8000_0000);
      load_element(FUNC_WRITE_SECOND, 3'd1, 3'd1, 32'h0000_0000);
      send_beat(FUNC_COMPUTE, 3'd5, 3'd2, 32'h1234_5678);

      // Random phases: pick a size, reload part of the square, compute.
      while (items_sent < ITEM_TARGET) begin
         case ($urandom_range(0, 9))
            0: size_code = 4'd0;
            1: size_code = 4'd15;
            2: size_code = 4'd8;
            3: size_code = SIZE_W'($urandom_range(9, 15));
            4: size_code = 4'd1;
            default: size_code = SIZE_W'($urandom_range(2, 4));
         endcase
         if (size_code == 0)
            dim = 1;
         else if (size_code > SMM_MAX_SIZE)
            dim = SMM_MAX_SIZE;
         else
            dim = int'(size_code);
         set_size(size_code);
         repeat ($urandom_range(1, 3)) begin
            // Overwrite a few elements inside the active square.
            repeat ($urandom_range(0, dim * dim)) begin
               load_element(pick_matrix(), IDX_W'($urandom_range(0, dim - 1)),
                            IDX_W'($urandom_range(0, dim - 1)), pick_value());
            end
            // Noise: the spare code and writes anywhere in the store.
            repeat ($urandom_range(0, 2)) begin
               if ($urandom_range(0, 1) != 0)
                  send_beat(FUNC_UNUSED, IDX_W'($urandom), IDX_W'($urandom), $urandom);
               else
                  load_element(pick_matrix(), IDX_W'($urandom), IDX_W'($urandom),
                               pick_value());
            end
            // Every element the product reads must have been written.
            for (int r = 0; r < dim; r++) begin
               for (int c = 0; c < dim; c++) begin
                  if (!first_loaded[r * SMM_MAX_SIZE + c])
                     load_element(FUNC_WRITE_FIRST, IDX_W'(r), IDX_W'(c), pick_value());
                  if (!second_loaded[r * SMM_MAX_SIZE + c])
                     load_element(FUNC_WRITE_SECOND, IDX_W'(r), IDX_W'(c), pick_value());
               end
            end
            send_beat(FUNC_COMPUTE, IDX_W'($urandom), IDX_W'($urandom), $urandom);
         end
      end

      settle();
      if (mismatch_count == 0)
         $display("** square_integer_matrix_multiply_core: PASSED **");
      else
         $display("** square_integer_matrix_multiply_core: FAILED **");
      $finish;
   end

endmodule
